@@ rtl/text_console_cell_engine_core_assert.svh @@
// Assertion macros for the text console cell engine.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef TEXT_CONSOLE_CELL_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCCE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tcce_pkg.sv @@
// Shared types and constants of the text console cell engine.
// No dependencies; imported by the controller, the datapath and the top level.
package tcce_pkg;

	localparam int CMD_W       = 3;
	localparam int CHAR_W      = 8;
	localparam int COLOR_W     = 4;
	localparam int INDEX_W     = 11;
	localparam int CURSOR_W    = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;

	// Request opcodes.
	localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BACK    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_NEWLINE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_FG = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_BG = 1'd1;

	localparam logic [COLOR_W-1:0] BLANK_FG_RESET = 4'hF;
	localparam logic [COLOR_W-1:0] BLANK_BG_RESET = 4'h0;
	localparam logic [CHAR_W-1:0]  BLANK_CHAR     = 8'h20;

	// One stored cell: character in the low byte, then foreground, then background.
	typedef struct packed {
		logic [COLOR_W-1:0] bg;
		logic [COLOR_W-1:0] fg;
		logic [CHAR_W-1:0]  ch;
	} cell_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // latch the request fields
		logic exec;      // carry out the latched command
		logic sweep_run; // step the scroll or clear sweep
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             row_full;
		logic             sweep_last;
		logic             pipe_wr;
	} dp_sts_t;

endpackage

@@ rtl/tcce_ctrl.sv @@
// Controller state machine of the text console cell engine.
// Depends on tcce_pkg for the command and status structs and the opcodes.
module tcce_ctrl import tcce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_sts_t  sts,
	output ctl_cmd_t ctl,
	output logic     busy,
	output logic     done
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_SWEEP = 5'b00100,
		S_DRAIN = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   need_scroll;

	assign need_scroll = (sts.cmd == CMD_PUT) && sts.row_full;

	assign busy = !((state_q == S_IDLE) || (state_q == S_RESP));
	assign done = (state_q == S_RESP);

	assign ctl.load      = start && !busy;
	assign ctl.exec      = (state_q == S_EXEC) && !need_scroll;
	assign ctl.sweep_run = (state_q == S_SWEEP);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (need_scroll || (sts.cmd == CMD_CLEAR)) state_d = S_SWEEP;
				else state_d = S_RESP;
			end
			S_SWEEP: begin
				if (sts.sweep_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				// After a scroll the pending character still has to be written.
				if (sts.cmd == CMD_PUT) state_d = S_EXEC;
				else state_d = S_RESP;
			end
			S_RESP: begin
				if (start) state_d = S_EXEC;
				else state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

@@ rtl/tcce_datapath.sv @@
// Datapath of the text console cell engine: cell store, position registers,
// sweep pipeline and result fields. Depends on tcce_pkg.
module tcce_datapath import tcce_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               ctl,
	output dp_sts_t                sts,
	input  logic [CMD_W-1:0]       cmd,
	input  logic [CHAR_W-1:0]      char_code,
	input  logic [COLOR_W-1:0]     fg,
	input  logic [COLOR_W-1:0]     bg,
	input  logic [INDEX_W-1:0]     cell_index,
	input  logic                   cfg_wr,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic [CURSOR_W-1:0]    cursor_pos,
	output logic [CHAR_W-1:0]      cell_char,
	output logic [COLOR_W-1:0]     cell_fg,
	output logic [COLOR_W-1:0]     cell_bg
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int POS_W      = $clog2(CELL_COUNT + 1);
	localparam int ROW_W      = $clog2(ROWS + 1);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_FULL  = ROW_W'(ROWS);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELL_COUNT - 1);

	cell_t mem [0:CELL_COUNT-1];

	logic [CMD_W-1:0]   req_cmd_q;
	logic [CHAR_W-1:0]  req_char_q;
	logic [COLOR_W-1:0] req_fg_q;
	logic [COLOR_W-1:0] req_bg_q;
	logic [INDEX_W-1:0] req_idx_q;
	logic [COLOR_W-1:0] blank_fg_q;
	logic [COLOR_W-1:0] blank_bg_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [POS_W-1:0]   hw_q;
	logic [ADDR_W-1:0]  sweep_q;
	cell_t              rd_q;
	logic               wr_vld_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;
	logic               wr_blank_s1;

	logic              is_put, is_back, is_clear, is_read;
	logic              idx_ok, row_full, sweep_last, sweep_blank;
	logic [POS_W-1:0]  pos, back_pos;
	logic              cmd_wr;
	logic [ADDR_W-1:0] cmd_wr_addr;
	cell_t             cmd_wr_data, blank_cell;
	logic              mem_wr;
	logic [ADDR_W-1:0] mem_wr_addr;
	cell_t             mem_wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	int                rd_copy_addr;

	assign is_put   = (req_cmd_q == CMD_PUT);
	assign is_back  = (req_cmd_q == CMD_BACK);
	assign is_clear = (req_cmd_q == CMD_CLEAR);
	assign is_read  = (req_cmd_q == CMD_READ);
	assign idx_ok   = int'(req_idx_q) < CELL_COUNT;
	assign row_full = (row_q == ROW_FULL);

	// Linear position of the current column and row; backspace saturates at zero.
	assign pos      = POS_W'(int'(row_q) * COLUMNS + int'(col_q));
	assign back_pos = (pos == '0) ? '0 : pos - POS_W'(1);

	assign blank_cell  = '{bg: blank_bg_q, fg: blank_fg_q, ch: BLANK_CHAR};
	assign cmd_wr      = ctl.exec && (is_put || is_back);
	assign cmd_wr_addr = ADDR_W'(is_put ? pos : back_pos);
	assign cmd_wr_data = '{bg: req_bg_q, fg: req_fg_q, ch: (is_put ? req_char_q : BLANK_CHAR)};

	// Sweep: a clear blanks every cell; a scroll copies each cell from one row
	// below and blanks the bottom row.
	assign sweep_last   = (sweep_q == ADDR_LAST);
	assign sweep_blank  = is_clear || (int'(sweep_q) >= CELL_COUNT - COLUMNS);
	assign rd_copy_addr = int'(sweep_q) + COLUMNS;

	always_comb begin
		if (ctl.sweep_run) begin
			rd_en   = !sweep_blank;
			rd_addr = sweep_blank ? '0 : ADDR_W'(rd_copy_addr);
		end else begin
			rd_en   = ctl.exec && is_read && idx_ok;
			rd_addr = idx_ok ? ADDR_W'(req_idx_q) : '0;
		end
	end

	// The sweep write follows its read in the next cycle; command writes never overlap it.
	assign mem_wr      = cmd_wr || wr_vld_s1;
	assign mem_wr_addr = wr_vld_s1 ? wr_addr_s1 : cmd_wr_addr;
	assign mem_wr_data = wr_vld_s1 ? (wr_blank_s1 ? blank_cell : rd_q) : cmd_wr_data;

	always_ff @(posedge clk) begin
		if (mem_wr) mem[mem_wr_addr] <= mem_wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		wr_addr_s1  <= sweep_q;
		wr_blank_s1 <= sweep_blank;
		if (ctl.load) begin
			req_cmd_q  <= cmd;
			req_char_q <= char_code;
			req_fg_q   <= fg;
			req_bg_q   <= bg;
			req_idx_q  <= cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s1 <= 1'b0;
			sweep_q   <= '0;
		end else begin
			wr_vld_s1 <= ctl.sweep_run;
			sweep_q   <= ctl.sweep_run ? sweep_q + ADDR_W'(1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_fg_q <= BLANK_FG_RESET;
			blank_bg_q <= BLANK_BG_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_BLANK_FG: blank_fg_q <= cfg_data;
				CFG_BLANK_BG: blank_bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			hw_q  <= '0;
		end else if (ctl.exec) begin
			case (req_cmd_q)
				CMD_PUT: begin
					// Position after the advance is always one past the written cell.
					hw_q <= pos + POS_W'(1);
					if (col_q == COL_LAST) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				CMD_BACK: begin
					hw_q <= back_pos;
					if (col_q == '0) begin
						if (row_q != '0) begin
							row_q <= row_q - ROW_W'(1);
							col_q <= COL_LAST;
						end
					end else begin
						col_q <= col_q - COL_W'(1);
					end
				end
				CMD_NEWLINE: begin
					if (!row_full) row_q <= row_q + ROW_W'(1);
					col_q <= '0;
				end
				CMD_CLEAR: begin
					col_q <= '0;
					row_q <= '0;
					hw_q  <= '0;
				end
				default: ;
			endcase
		end else if (ctl.sweep_run && sweep_last && !is_clear) begin
			row_q <= ROW_LAST;
		end
	end

	assign sts.cmd        = req_cmd_q;
	assign sts.row_full   = row_full;
	assign sts.sweep_last = sweep_last;
	assign sts.pipe_wr    = wr_vld_s1;

	assign cursor_pos = CURSOR_W'(hw_q);
	assign cell_char  = (is_read && idx_ok) ? rd_q.ch : '0;
	assign cell_fg    = (is_read && idx_ok) ? rd_q.fg : '0;
	assign cell_bg    = (is_read && idx_ok) ? rd_q.bg : '0;

endmodule

@@ rtl/text_console_cell_engine_core.sv @@
// Top level of the text console cell engine: controller plus datapath.
// Depends on tcce_pkg, tcce_ctrl, tcce_datapath and the assertion macro header.
//
// Usage. A request (cmd, char_code, fg, bg, cell_index) is taken at a rising
// edge where start is high and busy is low. Every request yields exactly one
// result: done is high for one cycle while cursor_pos, cell_char, cell_fg and
// cell_bg hold it. The receiver cannot stall, so the result is gone after that
// cycle. Put char, backspace, new line, read cell and unused opcodes give done
// in the second cycle after acceptance, and busy is already low in that cycle,
// so a new request may be taken there: one request every two cycles. The work
// cycle does at most one write and one read on the single cell store.
// Clear, and a put char that must first scroll, sweep the whole store one cell
// per cycle through a one-stage read/write pipeline. After the sweep a drain
// state lets the last write finish; a scroll then returns to the work state
// to write the pending character before the result.
// Configuration writes (blank_fg index 0, blank_bg index 1) are always ready
// and belong in idle time. Reset homes column, row and cursor, restores the
// blank colors and takes effect at once; the cell store is not cleared, so a
// cell is meaningful only once written.
module text_console_cell_engine_core import tcce_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [CMD_W-1:0]       cmd,
	input  logic [CHAR_W-1:0]      char_code,
	input  logic [COLOR_W-1:0]     fg,
	input  logic [COLOR_W-1:0]     bg,
	input  logic [INDEX_W-1:0]     cell_index,
	output logic                   done,
	output logic [CURSOR_W-1:0]    cursor_pos,
	output logic [CHAR_W-1:0]      cell_char,
	output logic [COLOR_W-1:0]     cell_fg,
	output logic [COLOR_W-1:0]     cell_bg,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "text_console_cell_engine_core_assert.svh"

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// The register file takes a write in any cycle.
	assign cfg_ready = 1'b1;

	tcce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	tcce_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.char_code  (char_code),
		.fg         (fg),
		.bg         (bg),
		.cell_index (cell_index),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cursor_pos (cursor_pos),
		.cell_char  (cell_char),
		.cell_fg    (cell_fg),
		.cell_bg    (cell_bg)
	);

	// A command write must never meet a trailing sweep write on the store port.
	`TCCE_ASSERT_IMP(a_no_wr_clash, ctl.exec, !sts.pipe_wr, "command write collides with sweep write")
	// An accepted request keeps the block busy in the following cycle.
	`TCCE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	// The last sweep step is followed by the drain cycle, never by a result.
	`TCCE_ASSERT_NEXT(a_sweep_drain, ctl.sweep_run && sts.sweep_last, !ctl.sweep_run && busy && !done, "sweep did not drain")
	// A result only follows a cycle of work.
	`TCCE_ASSERT_IMP(a_done_after_work, done, $past(busy), "result without preceding work")

endmodule
